@@ hw/rtl/ovl_pkg.sv @@
// shared types and codes for the ordered value list
`timescale 1ns / 1ps
`default_nettype none

package ovl_pkg;

  localparam int VAL_W = 32;
  localparam int POS_W = 5;

  typedef enum logic [1:0] {
    REQ_INSERT = 2'd0,
    REQ_DELETE = 2'd1,
    REQ_SEARCH = 2'd2,
    REQ_NONE   = 2'd3
  } req_t;

  typedef enum logic [1:0] {
    ST_OK        = 2'd0,
    ST_EMPTY     = 2'd1,
    ST_NOT_FOUND = 2'd2,
    ST_FULL      = 2'd3
  } status_t;

  typedef struct packed {
    logic signed [VAL_W-1:0] key;
    logic                    shift;
    logic                    clear;
  } ovl_ctl_t;

endpackage

`default_nettype wire

@@ hw/rtl/ovl_cell.sv @@
// one list cell: stored value, compare against key, travelling scan token
`timescale 1ns / 1ps
`default_nettype none

module ovl_cell
  import ovl_pkg::*;
(
  input  wire logic                    clk,
  input  wire logic                    rst,
  input  wire ovl_ctl_t                ctl,
  input  wire logic                    wr,
  input  wire logic                    tok_in,
  input  wire logic signed [VAL_W-1:0] value_in,
  output logic signed [VAL_W-1:0]      value,
  output logic                         tok,
  output logic                         hit
);

  assign hit = tok && (value == ctl.key);

  always_ff @(posedge clk) begin
    if (rst) begin
      tok <= 1'b0;
    end else if (ctl.clear) begin
      tok <= 1'b0;
    end else begin
      tok <= tok_in;
    end
  end

  // write on insert, or take right neighbour's value while closing a gap
  always_ff @(posedge clk) begin
    if (wr) begin
      value <= ctl.key;
    end else if (ctl.shift && tok) begin
      value <= value_in;
    end
  end

endmodule

`default_nettype wire

@@ hw/rtl/ordered_value_list_unit.sv @@
// top level: ordered value list built as a row of cells with a scan token
// insert and empty/unused requests give their result in the cycle after start is accepted
// search/delete: a token walks one cell per cycle from the head, visiting up to count
// cells; delete continues to the tail to close the gap
// busy is high while a search or delete is in progress; results cannot be stalled
// synchronous reset empties the list; stored values need no clearing
`timescale 1ns / 1ps
`default_nettype none

module ordered_value_list_unit
  import ovl_pkg::*;
#(
  parameter int CAPACITY = 16
) (
  input  wire logic                    clk,
  input  wire logic                    rst,
  input  wire logic                    start,
  output logic                         busy,
  input  wire logic [1:0]              req_type,
  input  wire logic signed [VAL_W-1:0] item_value,
  output logic                         done,
  output logic [1:0]                   status,
  output logic [POS_W-1:0]             position
);

  localparam int CNT_W = $clog2(CAPACITY + 1);

  typedef enum logic [1:0] {
    IDLE,
    SCAN,
    SHIFT
  } state_t;

  state_t                  state;
  logic [CNT_W-1:0]        count;
  logic [CNT_W-1:0]        pos;
  logic                    is_delete;
  logic signed [VAL_W-1:0] key;
  logic                    launch;

  ovl_ctl_t                ctl;
  logic                    accept;
  logic                    found;
  logic                    last;
  logic                    next_last;
  logic                    clear;
  logic [31:0]             pos_plus1;

  logic signed [VAL_W-1:0] cell_value [CAPACITY];
  logic [CAPACITY-1:0]     cell_tok;
  logic [CAPACITY-1:0]     cell_hit;
  logic [CAPACITY-1:0]     cell_wr;

  assign busy      = (state != IDLE);
  assign accept    = start && !busy;
  assign found     = |cell_hit;
  assign pos_plus1 = 32'(pos) + 32'd1;
  assign last      = (pos_plus1 >= 32'(count));
  assign next_last = (pos_plus1 + 32'd1 >= 32'(count));
  assign launch    = accept && ((req_type == REQ_DELETE) || (req_type == REQ_SEARCH)) &&
                     (count != '0);

  always_comb begin
    clear = 1'b0;
    unique case (state)
      IDLE:    clear = 1'b0;
      SCAN:    clear = last || (found && (!is_delete || next_last));
      SHIFT:   clear = next_last;
      default: clear = 1'b1;
    endcase
  end

  assign ctl.key   = accept ? item_value : key;
  assign ctl.clear = clear;
  assign ctl.shift = (state == SHIFT) ||
                     ((state == SCAN) && found && is_delete && !last);

  genvar i;
  generate
    for (i = 0; i < CAPACITY; i++) begin : g_cell
      logic                    tin;
      logic signed [VAL_W-1:0] vin;

      assign cell_wr[i] = accept && (req_type == REQ_INSERT) &&
                          (count == CNT_W'(i));
      if (i == 0) begin : g_head
        assign tin = launch;
      end else begin : g_body
        assign tin = cell_tok[i-1];
      end
      if (i == CAPACITY - 1) begin : g_tail
        assign vin = cell_value[i];
      end else begin : g_mid
        assign vin = cell_value[i+1];
      end

      ovl_cell u_cell (
        .clk      (clk),
        .rst      (rst),
        .ctl      (ctl),
        .wr       (cell_wr[i] && (count != CNT_W'(CAPACITY))),
        .tok_in   (tin),
        .value_in (vin),
        .value    (cell_value[i]),
        .tok      (cell_tok[i]),
        .hit      (cell_hit[i])
      );
    end
  endgenerate

  // key register holds the request value for the scan; insert writes the key straight from the port
  always_ff @(posedge clk) begin
    if (accept) begin
      key <= item_value;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= IDLE;
      count     <= '0;
      pos       <= '0;
      is_delete <= 1'b0;
      done      <= 1'b0;
      status    <= ST_OK;
      position  <= '0;
    end else begin
      done     <= 1'b0;
      position <= '0;
      unique case (state)
        IDLE: begin
          if (accept) begin
            unique case (req_type)
              REQ_INSERT: begin
                done <= 1'b1;
                if (count == CNT_W'(CAPACITY)) begin
                  status <= ST_FULL;
                end else begin
                  status <= ST_OK;
                  count  <= count + CNT_W'(1);
                end
              end
              REQ_DELETE, REQ_SEARCH: begin
                if (count == '0) begin
                  done   <= 1'b1;
                  status <= ST_EMPTY;
                end else begin
                  is_delete <= (req_type == REQ_DELETE);
                  pos       <= '0;
                  state     <= SCAN;
                end
              end
              default: begin
                done   <= 1'b1;
                status <= ST_OK;
              end
            endcase
          end
        end
        SCAN: begin
          priority if (found && !is_delete) begin
            done     <= 1'b1;
            status   <= ST_OK;
            position <= pos_plus1[POS_W-1:0];
            state    <= IDLE;
          end else if (found && (last || next_last)) begin
            done   <= 1'b1;
            status <= ST_OK;
            count  <= count - CNT_W'(1);
            state  <= IDLE;
          end else if (found) begin
            pos   <= pos + CNT_W'(1);
            state <= SHIFT;
          end else if (last) begin
            done   <= 1'b1;
            status <= ST_NOT_FOUND;
            state  <= IDLE;
          end else begin
            pos <= pos + CNT_W'(1);
          end
        end
        SHIFT: begin
          if (next_last) begin
            done   <= 1'b1;
            status <= ST_OK;
            count  <= count - CNT_W'(1);
            state  <= IDLE;
          end else begin
            pos <= pos + CNT_W'(1);
          end
        end
        default: begin
          state <= IDLE;
        end
      endcase
    end
  end

endmodule

`default_nettype wire
